// ===== rtl/pts_pkg.sv =====
// Package for the periodic timer scheduler: opcodes, result kinds, FSM states,
// and the command and token flag structs shared by the control and the cell chain.
// No dependencies.
package pts_pkg;

    localparam int IN_TIME_W   = 32;
    localparam int REP_W       = 32;
    localparam int ID_W        = 4;
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SCHED  = 2'd1,
        OP_CANCEL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_FULL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic clear_done;
        logic cancel;
        logic load;
        logic fire;
        logic free_zero;
        logic free_all;
    } cmd_t;

    // flags of the search token that walks down the chain
    typedef struct packed {
        logic found;
        logic more;
        logic free_found;
    } tok_flags_t;

endpackage

// ===== rtl/pts_cell.sv =====
// One timer slot of the scheduler chain: slot state plus one stage of the
// search token (earliest due timer, first free slot). Depends on pts_pkg.
module pts_cell
    import pts_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int SLOT_W    = 4,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [SLOT_W-1:0]    cmd_idx,
    input  logic [TIME_BITS-1:0] now_t,
    input  logic [TIME_BITS-1:0] load_due,
    input  logic [TIME_BITS-1:0] load_period,
    input  logic [REP_W-1:0]     load_rep,
    input  logic [TIME_BITS-1:0] key_due,
    input  logic [SLOT_W-1:0]    key_idx,
    input  tok_flags_t           tin,
    input  logic [TIME_BITS-1:0] tin_due,
    input  logic [SLOT_W-1:0]    tin_idx,
    input  logic [REP_W-1:0]     tin_rep,
    input  logic [SLOT_W-1:0]    tin_free_idx,
    output tok_flags_t           tout,
    output logic [TIME_BITS-1:0] tout_due,
    output logic [SLOT_W-1:0]    tout_idx,
    output logic [REP_W-1:0]     tout_rep,
    output logic [SLOT_W-1:0]    tout_free_idx
);

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

    logic                 valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS-1:0] due_reg, due_next;
    logic [TIME_BITS-1:0] period_reg, period_next;
    logic [REP_W-1:0]     rep_reg, rep_next;

    tok_flags_t           tok_reg, tok_next;
    logic [TIME_BITS-1:0] tok_due_reg, tok_due_next;
    logic [SLOT_W-1:0]    tok_idx_reg, tok_idx_next;
    logic [REP_W-1:0]     tok_rep_reg, tok_rep_next;
    logic [SLOT_W-1:0]    tok_free_reg, tok_free_next;

    logic                 hit;
    logic                 pending;
    logic                 elig;
    logic                 zero;
    logic                 take;
    logic                 ahead;
    logic [TIME_BITS:0]   adv_sum;
    logic [TIME_BITS-1:0] adv_due;

    assign hit     = (cmd_idx == MY_IDX);
    assign pending = valid_reg && !done_reg && (due_reg < now_t);
    assign elig    = pending && (rep_reg != '0);
    assign zero    = pending && (rep_reg == '0);
    // strict compare: on a tie the lower slot, seen earlier, keeps the token
    assign take    = elig && (!tin.found || (due_reg < tin_due));
    // before the last fired timer in firing order
    assign ahead   = (due_reg < key_due) || ((due_reg == key_due) && (MY_IDX < key_idx));

    assign adv_sum = {1'b0, due_reg} + {1'b0, period_reg};
    assign adv_due = adv_sum[TIME_BITS] ? '1 : adv_sum[TIME_BITS-1:0];

    always_comb
    begin
        valid_next  = valid_reg;
        done_next   = done_reg;
        due_next    = due_reg;
        period_next = period_reg;
        rep_next    = rep_reg;
        if (cmd.clear_done)
        begin
            done_next = 1'b0;
        end
        if (cmd.cancel && hit)
        begin
            valid_next = 1'b0;
        end
        if (cmd.load && hit)
        begin
            valid_next  = 1'b1;
            done_next   = 1'b0;
            due_next    = load_due;
            period_next = load_period;
            rep_next    = load_rep;
        end
        if (cmd.fire && hit)
        begin
            rep_next  = rep_reg - REP_W'(1);
            due_next  = adv_due;
            done_next = 1'b1;
            if (rep_reg == REP_W'(1))
            begin
                valid_next = 1'b0;
            end
        end
        if (cmd.free_zero && zero && (cmd.free_all || ahead))
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        tok_next.found      = tin.found | elig;
        tok_next.more       = tin.more | (tin.found & elig);
        tok_next.free_found = tin.free_found | !valid_reg;
        tok_due_next        = take ? due_reg : tin_due;
        tok_idx_next        = take ? MY_IDX : tin_idx;
        tok_rep_next        = take ? rep_reg : tin_rep;
        tok_free_next       = tin.free_found ? tin_free_idx : MY_IDX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg      <= due_next;
        period_reg   <= period_next;
        rep_reg      <= rep_next;
        tok_due_reg  <= tok_due_next;
        tok_idx_reg  <= tok_idx_next;
        tok_rep_reg  <= tok_rep_next;
        tok_free_reg <= tok_free_next;
    end

    assign tout          = tok_reg;
    assign tout_due      = tok_due_reg;
    assign tout_idx      = tok_idx_reg;
    assign tout_rep      = tok_rep_reg;
    assign tout_free_idx = tok_free_reg;

endmodule

// ===== rtl/periodic_timer_scheduler_unit.sv =====
// Periodic timer scheduler top level: control sequencer plus a chain of
// SLOTS pts_cell instances. Depends on pts_pkg and pts_cell.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   operation, now, interval, repeats, slot
//  out       output     out_valid / out_ready kind, slot_id, repeats_left, last
//
// Cancel and unused codes are taken without leaving idle; a schedule waits for one
// pass of the search token. A tick makes one pass per fired timer, and one when nothing fires:
// each firing waits for the search token to walk the whole cell chain.
// Reset clears all slots at once; no clearing pass.
// A full output register holds the block at the end of a pass until taken.
module periodic_timer_scheduler_unit
    import pts_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [IN_TIME_W-1:0] now,
    input  logic [IN_TIME_W-1:0] interval,
    input  logic [REP_W-1:0]     repeats,
    input  logic [ID_W-1:0]      slot,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [ID_W-1:0]      slot_id,
    output logic [REP_W-1:0]     repeats_left,
    output logic                 last
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [N_W-1:0]       n_reg, n_next;
    logic                 sched_reg, sched_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] ivl_reg, ivl_next;
    logic [REP_W-1:0]     rep_reg, rep_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                kind_reg, kind_next;
    logic [ID_W-1:0]      slot_id_reg, slot_id_next;
    logic [REP_W-1:0]     left_reg, left_next;
    logic                 last_reg, last_next;

    cmd_t                 cmd;
    logic [SLOT_W-1:0]    cmd_idx;
    logic [TIME_BITS:0]   sched_sum;
    logic [TIME_BITS-1:0] sched_due;
    logic                 out_free;
    logic                 fire_last;

    tok_flags_t           chain_flags [SLOTS+1];
    logic [TIME_BITS-1:0] chain_due   [SLOTS+1];
    logic [SLOT_W-1:0]    chain_idx   [SLOTS+1];
    logic [REP_W-1:0]     chain_rep   [SLOTS+1];
    logic [SLOT_W-1:0]    chain_free  [SLOTS+1];

    tok_flags_t           fin;
    logic [TIME_BITS-1:0] fin_due;
    logic [SLOT_W-1:0]    fin_idx;
    logic [REP_W-1:0]     fin_rep;
    logic [SLOT_W-1:0]    fin_free;

    // empty token enters the head of the chain
    assign chain_flags[0] = '0;
    assign chain_due[0]   = '0;
    assign chain_idx[0]   = '0;
    assign chain_rep[0]   = '0;
    assign chain_free[0]  = '0;

    assign sched_sum = {1'b0, now_reg} + {1'b0, ivl_reg};
    assign sched_due = sched_sum[TIME_BITS] ? '1 : sched_sum[TIME_BITS-1:0];

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pts_cell #(
            .TIME_BITS (TIME_BITS),
            .SLOT_W    (SLOT_W),
            .INDEX     (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .cmd_idx       (cmd_idx),
            .now_t         (now_reg),
            .load_due      (sched_due),
            .load_period   (ivl_reg),
            .load_rep      (rep_reg),
            .key_due       (fin_due),
            .key_idx       (fin_idx),
            .tin           (chain_flags[g]),
            .tin_due       (chain_due[g]),
            .tin_idx       (chain_idx[g]),
            .tin_rep       (chain_rep[g]),
            .tin_free_idx  (chain_free[g]),
            .tout          (chain_flags[g+1]),
            .tout_due      (chain_due[g+1]),
            .tout_idx      (chain_idx[g+1]),
            .tout_rep      (chain_rep[g+1]),
            .tout_free_idx (chain_free[g+1])
        );
    end

    assign fin      = chain_flags[SLOTS];
    assign fin_due  = chain_due[SLOTS];
    assign fin_idx  = chain_idx[SLOTS];
    assign fin_rep  = chain_rep[SLOTS];
    assign fin_free = chain_free[SLOTS];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign fire_last = !fin.more || (n_reg == N_W'(MAX_RESULTS - 1));

    always_comb
    begin
        cmd            = '0;
        cmd_idx        = fin_idx;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        sched_next     = sched_reg;
        now_next       = now_reg;
        ivl_next       = ivl_reg;
        rep_next       = rep_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        slot_id_next   = slot_id_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_TICK:
                        begin
                            cmd.clear_done = 1'b1;
                            now_next       = TIME_BITS'(now);
                            n_next         = '0;
                            sched_next     = 1'b0;
                            cnt_next       = CNT_W'(SLOTS);
                            state_next     = S_SCAN;
                        end
                        OP_SCHED:
                        begin
                            now_next   = TIME_BITS'(now);
                            ivl_next   = TIME_BITS'(interval);
                            rep_next   = repeats;
                            sched_next = 1'b1;
                            cnt_next   = CNT_W'(SLOTS);
                            state_next = S_SCAN;
                        end
                        OP_CANCEL:
                        begin
                            cmd.cancel = (32'(slot) < 32'(SLOTS));
                            cmd_idx    = SLOT_W'(slot);
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else if (sched_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                        if (fin.free_found)
                        begin
                            cmd.load     = 1'b1;
                            cmd_idx      = fin_free;
                            kind_next    = KIND_SCHED;
                            slot_id_next = ID_W'(fin_free);
                            left_next    = rep_reg;
                        end
                        else
                        begin
                            kind_next    = KIND_FULL;
                            slot_id_next = '0;
                            left_next    = '0;
                        end
                    end
                end
                else if (!fin.found)
                begin
                    // nothing left to fire: drop every due zero-count timer
                    cmd.free_zero = 1'b1;
                    cmd.free_all  = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (out_free)
                begin
                    cmd.fire       = 1'b1;
                    cmd_idx        = fin_idx;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FIRED;
                    slot_id_next   = ID_W'(fin_idx);
                    left_next      = fin_rep - REP_W'(1);
                    last_next      = fire_last;
                    if (fire_last)
                    begin
                        // at the result limit only timers ahead of this one are dropped
                        cmd.free_zero = 1'b1;
                        cmd.free_all  = (n_reg != N_W'(MAX_RESULTS - 1));
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        n_next   = n_reg + N_W'(1);
                        cnt_next = CNT_W'(SLOTS);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            sched_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            sched_reg     <= sched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        ivl_reg     <= ivl_next;
        rep_reg     <= rep_next;
        kind_reg    <= kind_next;
        slot_id_reg <= slot_id_next;
        left_reg    <= left_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign slot_id      = slot_id_reg;
    assign repeats_left = left_reg;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    // a non-final result means the tick is still scanning for the next one
    a_more_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> state_reg == S_SCAN)
        else $error("non-final result while idle");

    // results are only produced when a pass has finished
    a_out_from_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_SCAN && cnt_reg == '0))
        else $error("result loaded outside end of pass");

    // schedule answers are single results
    a_sched_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind_reg == KIND_SCHED || kind_reg == KIND_FULL) |-> last)
        else $error("schedule answer without last");

    // pass counter is always spent when the sequencer is idle
    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> cnt_reg == '0)
        else $error("pass counter running while idle");
`endif

endmodule

// ===== verif/periodic_timer_scheduler_checker.sv =====
// Scoreboard for periodic_timer_scheduler_unit: keeps its own copy of the timer table,
// predicts the result items of each accepted input item and compares them in order.
// Depends on pts_pkg.
module periodic_timer_scheduler_checker
    import pts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [IN_TIME_W-1:0] now,
    input  logic [IN_TIME_W-1:0] interval,
    input  logic [REP_W-1:0]     repeats,
    input  logic [ID_W-1:0]      slot,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           kind,
    input  logic [ID_W-1:0]      slot_id,
    input  logic [REP_W-1:0]     repeats_left,
    input  logic                 last,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef struct {
        kind_t                kind;
        logic [ID_W-1:0]      slot_id;
        logic [REP_W-1:0]     repeats_left;
        logic                 last;
    } timer_event_t;

    // shadow timer table
    logic                 live [SLOTS];
    logic [IN_TIME_W-1:0] due  [SLOTS];
    logic [IN_TIME_W-1:0] per  [SLOTS];
    logic [REP_W-1:0]     left [SLOTS];

    timer_event_t timer_events[$];

    task automatic report(input string msg);
        if (errors < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [IN_TIME_W-1:0] sat_sum(input logic [IN_TIME_W-1:0] a,
                                                     input logic [IN_TIME_W-1:0] b);
        logic [IN_TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[IN_TIME_W] ? '1 : s[IN_TIME_W-1:0];
    endfunction

    function automatic timer_event_t make_event(input kind_t k, input int id,
                                                input logic [REP_W-1:0] r);
        timer_event_t ev;
        ev.kind         = k;
        ev.slot_id      = id[ID_W-1:0];
        ev.repeats_left = r;
        ev.last         = 1'b0;
        return ev;
    endfunction

    task automatic predict_timer_op(input logic [1:0] op, input logic [IN_TIME_W-1:0] t,
                                    input logic [IN_TIME_W-1:0] ivl,
                                    input logic [REP_W-1:0] rep, input logic [ID_W-1:0] sl);
        int           i;
        int           best;
        int           n;
        logic         fired [SLOTS];
        timer_event_t ev;
        timer_event_t burst[$];
        case (op)
            OP_SCHED:
            begin
                i = 0;
                while (i < SLOTS && live[i])
                    i++;
                if (i < SLOTS)
                begin
                    live[i] = 1'b1;
                    due[i]  = sat_sum(t, ivl);
                    per[i]  = ivl;
                    left[i] = rep;
                    ev = make_event(KIND_SCHED, i, rep);
                end
                else
                begin
                    ev = make_event(KIND_FULL, 0, '0);
                end
                ev.last = 1'b1;
                timer_events = {timer_events, ev};
            end
            OP_CANCEL:
            begin
                if (int'(sl) < SLOTS)
                    live[sl] = 1'b0;
            end
            OP_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                    fired[i] = 1'b0;
                n = 0;
                while (n < MAX_RESULTS)
                begin
                    best = -1;
                    for (i = 0; i < SLOTS; i++)
                        if (live[i] && !fired[i] && due[i] < t)
                            if (best < 0 || due[i] < due[best])
                                best = i;
                    if (best < 0)
                        break;
                    fired[best] = 1'b1;
                    // a timer with no repeats left is dropped silently
                    if (left[best] == 0)
                    begin
                        live[best] = 1'b0;
                        continue;
                    end
                    left[best] = left[best] - 1;
                    due[best]  = sat_sum(due[best], per[best]);
                    burst = {burst, make_event(KIND_FIRED, best, left[best])};
                    n++;
                    if (left[best] == 0)
                        live[best] = 1'b0;
                end
                for (i = 0; i < burst.size(); i++)
                begin
                    ev = burst[i];
                    ev.last = (i == burst.size() - 1);
                    timer_events = {timer_events, ev};
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_event();
        timer_event_t ev;
        if (timer_events.size() == 0)
        begin
            report($sformatf("unexpected result kind=%0d slot=%0d left=%0d last=%0d",
                             kind, slot_id, repeats_left, last));
            return;
        end
        ev = timer_events.pop_front();
        if (kind !== ev.kind)
            report($sformatf("kind %0d, expected %0d", kind, ev.kind));
        if (slot_id !== ev.slot_id)
            report($sformatf("slot_id %0d, expected %0d", slot_id, ev.slot_id));
        if (repeats_left !== ev.repeats_left)
            report($sformatf("repeats_left %0d, expected %0d", repeats_left,
                             ev.repeats_left));
        if (last !== ev.last)
            report($sformatf("last %0d, expected %0d", last, ev.last));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                live[i] = 1'b0;
            timer_events.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // results leave before the new item is predicted; the queue is FIFO anyway
            if (out_valid && out_ready)
                check_event();
            if (in_valid && in_ready)
                predict_timer_op(operation, now, interval, repeats, slot);
            pending = timer_events.size();
        end
    end

endmodule

// ===== verif/tb_periodic_timer_scheduler_unit.sv =====
// Testbench top for periodic_timer_scheduler_unit: clock, reset, directed and random
// stimulus, output back-pressure and the verdict. Depends on pts_pkg, the DUT and
// periodic_timer_scheduler_checker.
module tb_periodic_timer_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int         SLOTS          = 16;
    localparam int         TIME_BITS      = 32;
    localparam int         CLK_HALF       = 5;
    localparam int         RESET_CYCLES   = 6;
    localparam int         RANDOM_ITEMS   = 480;
    localparam int         CALM_ITEMS     = 60;
    localparam int         DRAIN_CYCLES   = 4 * (SLOTS + 1);
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           operation;
    logic [IN_TIME_W-1:0] now;
    logic [IN_TIME_W-1:0] interval;
    logic [REP_W-1:0]     repeats;
    logic [ID_W-1:0]      slot;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           kind;
    logic [ID_W-1:0]      slot_id;
    logic [REP_W-1:0]     repeats_left;
    logic                 last;
    logic                 calm;
    int                   errors;
    int                   pending;
    int                   quiet_cycles;

    periodic_timer_scheduler_unit #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now          (now),
        .interval     (interval),
        .repeats      (repeats),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot_id      (slot_id),
        .repeats_left (repeats_left),
        .last         (last)
    );

    periodic_timer_scheduler_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now          (now),
        .interval     (interval),
        .repeats      (repeats),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot_id      (slot_id),
        .repeats_left (repeats_left),
        .last         (last),
        .errors       (errors),
        .pending      (pending)
    );

    always #CLK_HALF clk = ~clk;

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [1:0] op, input logic [IN_TIME_W-1:0] t,
                             input logic [IN_TIME_W-1:0] ivl, input logic [REP_W-1:0] rep,
                             input logic [ID_W-1:0] sl);
        @(negedge clk);
        in_valid  = 1'b1;
        operation = op;
        now       = t;
        interval  = ivl;
        repeats   = rep;
        slot      = sl;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // output back-pressure: ready runs of random length broken by stall bursts, always ready when calm
    initial
    begin
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                @(negedge clk);
                out_ready = 1'b1;
            end
            else
            begin
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
                repeat (run)
                begin
                    @(negedge clk);
                    out_ready = 1'b1;
                end
                repeat ($urandom_range(1, 18))
                begin
                    @(negedge clk);
                    out_ready = 1'b0;
                end
            end
        end
    end

    initial
    begin
        int                   i;
        int                   pick;
        int                   sched_share;
        logic [IN_TIME_W-1:0] cur_time;
        logic [IN_TIME_W-1:0] ivl;
        logic [REP_W-1:0]     rep;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_TICK;
        now       = '0;
        interval  = '0;
        repeats   = '0;
        slot      = '0;
        calm      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tick, ignored code, cancel of a free slot
        send_item(OP_TICK, '0, '0, '0, '0);
        send_item(OP_UNUSED, '1, '1, '1, '1);
        send_item(OP_CANCEL, '0, '0, '0, ID_W'(SLOTS - 1));
        // zero-repeat timer, then one saturated at the top of the time range
        send_item(OP_SCHED, 32'd5, '0, '0, '0);
        send_item(OP_SCHED, 32'd5, '1, '1, '0);
        // fill the table; small intervals give equal due times
        for (i = 2; i < SLOTS; i++)
            send_item(OP_SCHED, 32'd5, i % 3, (i % 4) + 1, '0);
        send_item(OP_SCHED, 32'd5, 32'd1, 32'd1, '0);
        // due time equal to now does not fire
        send_item(OP_TICK, 32'd5, '0, '0, '0);
        send_item(OP_TICK, 32'd8, '0, '0, '0);
        send_item(OP_TICK, '1, '0, '0, '0);
        send_item(OP_CANCEL, '0, '0, '0, ID_W'(1));
        send_item(OP_SCHED, '1, 32'd2, 32'd3, '0);
        wait_for_results();

        cur_time = '0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
                wait_for_results();
            end
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
            if (!calm && $urandom_range(0, 3) == 0)
                idle($urandom_range(1, 18));
            if ($urandom_range(0, 49) == 0)
                cur_time = $urandom;
            // alternate schedule-heavy and tick-heavy stretches
            sched_share = ((i / 60) % 2) ? 55 : 30;
            pick = $urandom_range(0, 99);
            if (pick < sched_share)
            begin
                ivl = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 20);
                rep = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4);
                send_item(OP_SCHED, cur_time, ivl, rep, ID_W'($urandom_range(0, SLOTS - 1)));
            end
            else if (pick < 88)
            begin
                cur_time = cur_time + $urandom_range(0, 12);
                send_item(OP_TICK, cur_time, $urandom, $urandom,
                          ID_W'($urandom_range(0, SLOTS - 1)));
            end
            else if (pick < 97)
                send_item(OP_CANCEL, $urandom, $urandom, $urandom,
                          ID_W'($urandom_range(0, SLOTS - 1)));
            else
                send_item(OP_UNUSED, $urandom, $urandom, $urandom,
                          ID_W'($urandom_range(0, SLOTS - 1)));
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
